/* sv/circle_outline_intensity_sum_macros.svh */
// ----------------------------------------------------------------------------
// circle_outline_intensity_sum_macros
// assertion helpers used by the circle outline sum controller
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OUTLINE_INTENSITY_SUM_MACROS_SVH
`define CIRCLE_OUTLINE_INTENSITY_SUM_MACROS_SVH

// condition holds in the same cycle
`define COIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define COIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cois_pkg.sv */
// ----------------------------------------------------------------------------
// cois_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package cois_pkg;

  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 128;
  localparam int MAX_RADIUS   = 63;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 7;
  localparam int RAD_W  = 6;
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 17;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int P_W    = 10;
  localparam int MIR_W  = 3;

  localparam int IMG_DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;

  // input tdata layout, lowest bit first
  localparam int PCOL_LSB = 0;
  localparam int PROW_LSB = PCOL_LSB + COL_W;
  localparam int PVAL_LSB = PROW_LSB + ROW_W;
  localparam int CCOL_LSB = PVAL_LSB + PIX_W;
  localparam int CROW_LSB = CCOL_LSB + COL_W;
  localparam int RAD_LSB  = CROW_LSB + ROW_W;
  localparam int PART_LSB = RAD_LSB + RAD_W;
  localparam int IN_DATA_W  = ((PART_LSB + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SUM_W + 7) / 8) * 8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [MIR_W-1:0] MIR_LAST_PARTIAL = MIR_W'(3);
  localparam logic [MIR_W-1:0] MIR_LAST_FULL    = MIR_W'(7);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic             load_query;
    logic             mem_wr;
    logic             mem_rd;
    logic [MIR_W-1:0] mirror;
    logic             step;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic oob_in;
    logic more;
    logic partial;
  } sts_t;

endpackage

/* sv/cois_dp.sv */
// ----------------------------------------------------------------------------
// cois_dp
// image store, midpoint walk registers, mirror addressing, accumulator and result register
// ----------------------------------------------------------------------------
module cois_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [cois_pkg::IN_DATA_W-1:0]  in_tdata,
  input  cois_pkg::cmd_t                  cmd,
  output cois_pkg::sts_t                  sts,
  output logic [cois_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import cois_pkg::*;

  logic [COL_W-1:0] in_pcol, in_ccol;
  logic [ROW_W-1:0] in_prow, in_crow;
  logic [PIX_W-1:0] in_pval;
  logic [RAD_W-1:0] in_rad;
  logic             in_part;
  logic             oob_in;

  logic [COL_W-1:0]     cc_r;
  logic [ROW_W-1:0]     cr_r;
  logic [RAD_W-1:0]     x_r, y_r;
  logic signed [P_W-1:0] p_r, p_nxt, x_e, y_e;
  logic                 p_neg;
  logic                 partial_r, oob_r;

  logic [RAD_W-1:0]  row_off, col_off;
  logic              row_minus, col_minus;
  logic [ROW_W-1:0]  rd_row;
  logic [COL_W-1:0]  rd_col;
  logic [ADDR_W-1:0] addr;

  logic [PIX_W-1:0] mem [IMG_DEPTH];
  logic [PIX_W-1:0] mem_q_r;
  logic             rd_vld_r;
  logic [SUM_W-1:0] acc_r;
  logic [SUM_W:0]   acc_sum;
  logic [SUM_W-1:0] sum_out_r;
  logic             oob_out_r;

  assign in_pcol = in_tdata[PCOL_LSB +: COL_W];
  assign in_prow = in_tdata[PROW_LSB +: ROW_W];
  assign in_pval = in_tdata[PVAL_LSB +: PIX_W];
  assign in_ccol = in_tdata[CCOL_LSB +: COL_W];
  assign in_crow = in_tdata[CROW_LSB +: ROW_W];
  assign in_rad  = in_tdata[RAD_LSB  +: RAD_W];
  assign in_part = in_tdata[PART_LSB];

  // bounding box of the whole circle, also for partial queries
  assign oob_in = (in_rad > RAD_W'(MAX_RADIUS))
               || ({1'b0, in_ccol} < (COL_W+1)'(in_rad))
               || ({1'b0, in_crow} < (ROW_W+1)'(in_rad))
               || (({1'b0, in_ccol} + (COL_W+1)'(in_rad)) > (COL_W+1)'(IMAGE_WIDTH - 1))
               || (({1'b0, in_crow} + (ROW_W+1)'(in_rad)) > (ROW_W+1)'(IMAGE_HEIGHT - 1));

  assign x_e   = signed'({{(P_W-RAD_W){1'b0}}, x_r});
  assign y_e   = signed'({{(P_W-RAD_W){1'b0}}, y_r});
  assign p_neg = p_r[P_W-1];

  // increments folded onto the pre-step x and y
  assign p_nxt = p_neg ? p_r + (x_e <<< 1) + P_W'(3)
                       : p_r + ((x_e - y_e) <<< 1) + P_W'(5);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      cc_r      <= in_ccol;
      cr_r      <= in_crow;
      x_r       <= '0;
      y_r       <= in_rad;
      p_r       <= P_W'(1) - signed'({{(P_W-RAD_W){1'b0}}, in_rad});
      partial_r <= in_part;
      oob_r     <= oob_in;
    end else if (cmd.step) begin
      x_r <= x_r + RAD_W'(1);
      if (!p_neg) begin
        y_r <= y_r - RAD_W'(1);
      end
      p_r <= p_nxt;
    end
  end

  // mirror 0..3: (r+x,c+y) (r-x,c+y) (r-x,c-y) (r+x,c-y), 4..7 row y, col x
  assign row_off   = cmd.mirror[2] ? y_r : x_r;
  assign col_off   = cmd.mirror[2] ? x_r : y_r;
  assign row_minus = cmd.mirror[2] ? cmd.mirror[1] : (cmd.mirror[1] ^ cmd.mirror[0]);
  assign col_minus = cmd.mirror[2] ? (cmd.mirror[1] ^ cmd.mirror[0]) : cmd.mirror[1];
  assign rd_row = row_minus ? cr_r - ROW_W'(row_off) : cr_r + ROW_W'(row_off);
  assign rd_col = col_minus ? cc_r - COL_W'(col_off) : cc_r + COL_W'(col_off);

  assign addr = cmd.mem_wr ? {in_prow, in_pcol} : {rd_row, rd_col};

  // single port image store
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= in_pval;
    end
    if (cmd.mem_rd) begin
      mem_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.mem_rd;
    end
  end

  assign acc_sum = {1'b0, acc_r} + (SUM_W+1)'(mem_q_r);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sum_out_r <= oob_r ? '0 : acc_r;
      oob_out_r <= oob_r;
    end
  end

  assign out_tdata   = OUT_DATA_W'(sum_out_r);
  assign out_tuser   = oob_out_r;
  assign sts.oob_in  = oob_in;
  assign sts.more    = x_r < y_r;
  assign sts.partial = partial_r;

endmodule

/* sv/cois_ctrl.sv */
// ----------------------------------------------------------------------------
// cois_ctrl
// sequencer for pixel writes, the mirrored read walk and the result register
// ----------------------------------------------------------------------------
module cois_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  cois_pkg::sts_t sts,
  output cois_pkg::cmd_t cmd
);
  import cois_pkg::*;
  `include "circle_outline_intensity_sum_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [MIR_W-1:0] mir_r, mir_nxt, mir_last;
  logic             out_vld_r, out_vld_nxt;
  logic             in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign mir_last  = sts.partial ? MIR_LAST_PARTIAL : MIR_LAST_FULL;

  always_comb begin
    cmd        = '0;
    cmd.mirror = mir_r;
    state_nxt  = state_r;
    mir_nxt    = mir_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_WRITE) begin
            cmd.mem_wr = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            mir_nxt        = '0;
            state_nxt      = sts.oob_in ? S_DONE : S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.mem_rd = 1'b1;
        if (mir_r == mir_last) begin
          mir_nxt = '0;
          if (sts.more) begin
            cmd.step = 1'b1;
          end else begin
            state_nxt = S_DRAIN;
          end
        end else begin
          mir_nxt = mir_r + MIR_W'(1);
        end
      end
      S_DRAIN: begin
        // last read data still on its way into the accumulator
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mir_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mir_r     <= mir_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;

  `COIS_ASSERT_SAME(a_port_shared, cmd.mem_wr, !cmd.mem_rd, "image write and read collide")
  `COIS_ASSERT_SAME(a_out_free, cmd.load_out, !out_vld_r || out_tready, "result overwritten")
  `COIS_ASSERT_SAME(a_step_inside, cmd.step, sts.more && mir_r == mir_last, "walk step misplaced")
  `COIS_ASSERT_NEXT(a_oob_short, in_acc && in_tuser == MODE_QUERY && sts.oob_in, state_r == S_DONE, "out of bounds query walked")

endmodule

/* sv/circle_outline_intensity_sum.sv */
// ----------------------------------------------------------------------------
// circle_outline_intensity_sum: midpoint circle pixel sum over a 128x128 store
// pixel write: stored when accepted. query: load, one image read per cycle over n*8
// points (n*4 partial), n = walk points (up to 46 at radius 63), then DRAIN, DONE
// out of bounds query: no walk. reset clears control only, the store is not cleared
// ----------------------------------------------------------------------------
module circle_outline_intensity_sum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pixel_col, pixel_row, pixel_value, center_col, center_row, radius,
  // partial_only, zero pad
  input  logic [cois_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // intensity_sum, zero pad
  output logic [cois_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_of_bounds
  output logic                            out_tuser
);
  import cois_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cois_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cois_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

/* verif/circle_sum_checker.sv */
// ----------------------------------------------------------------------------
// circle_sum_checker
// watches both streams of the circle outline sum block, keeps a shadow copy
// of the image, predicts each query's outline sum and compares the results
// ----------------------------------------------------------------------------
module circle_sum_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [cois_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [cois_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  output int                              failures,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cois_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             oob;
  } outline_result_t;

  logic [PIX_W-1:0] shadow_image [IMG_DEPTH];
  outline_result_t  expected_sums [$];

  function automatic int pixel_at(input int row, input int col);
    if (row < 0 || col < 0 || row >= IMAGE_HEIGHT || col >= IMAGE_WIDTH) return 0;
    return int'(shadow_image[row * IMAGE_WIDTH + col]);
  endfunction

  // four points always, the other four only for a full circle
  function automatic int mirror_total(input int crow, input int ccol, input int x,
                                      input int y, input bit part);
    int acc;
    acc = pixel_at(crow + x, ccol + y) + pixel_at(crow - x, ccol + y)
        + pixel_at(crow - x, ccol - y) + pixel_at(crow + x, ccol - y);
    if (!part) begin
      acc += pixel_at(crow + y, ccol + x) + pixel_at(crow + y, ccol - x)
           + pixel_at(crow - y, ccol - x) + pixel_at(crow - y, ccol + x);
    end
    return acc;
  endfunction

  function automatic outline_result_t outline_total(input int ccol, input int crow,
                                                    input int rad, input bit part);
    outline_result_t res;
    int x;
    int y;
    int p;
    int acc;
    res.total = '0;
    res.oob   = 1'b0;
    // bounding box test covers the whole circle even in partial mode
    if (rad > MAX_RADIUS || ccol - rad < 0 || ccol + rad > IMAGE_WIDTH - 1 ||
        crow - rad < 0 || crow + rad > IMAGE_HEIGHT - 1) begin
      res.oob = 1'b1;
      return res;
    end
    x   = 0;
    y   = rad;
    p   = 1 - rad;
    acc = mirror_total(crow, ccol, x, y, part);
    while (x < y) begin
      x++;
      if (p < 0) begin
        p += 2 * x + 1;
      end else begin
        y--;
        p += 2 * (x - y) + 1;
      end
      acc += mirror_total(crow, ccol, x, y, part);
    end
    res.total = (acc > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outline_result_t  want;
    logic [SUM_W-1:0] got_sum;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == MODE_WRITE) begin
          shadow_image[int'(in_tdata[PROW_LSB +: ROW_W]) * IMAGE_WIDTH
                       + int'(in_tdata[PCOL_LSB +: COL_W])] = in_tdata[PVAL_LSB +: PIX_W];
        end else begin
          expected_sums = {expected_sums,
                           outline_total(int'(in_tdata[CCOL_LSB +: COL_W]),
                                         int'(in_tdata[CROW_LSB +: ROW_W]),
                                         int'(in_tdata[RAD_LSB +: RAD_W]),
                                         in_tdata[PART_LSB])};
        end
      end
      if (out_tvalid && out_tready) begin
        got_sum = out_tdata[SUM_W-1:0];
        if (expected_sums.size() == 0) begin
          if (failures < 10)
            $display("unexpected result transfer: sum %0d oob %0b", got_sum, out_tuser);
          failures <= failures + 1;
        end else begin
          want = expected_sums.pop_front();
          if (got_sum !== want.total || out_tuser !== want.oob) begin
            if (failures < 10)
              $display("sum mismatch: expected sum %0d oob %0b, got sum %0d oob %0b",
                       want.total, want.oob, got_sum, out_tuser);
            failures <= failures + 1;
          end
        end
      end
    end
    outstanding <= expected_sums.size();
  end

endmodule

/* verif/tb_circle_outline_intensity_sum.sv */
// ----------------------------------------------------------------------------
// tb_circle_outline_intensity_sum
// drives pixel writes and circle queries into the outline sum block with
// random gaps on both streams; every pixel a query touches is written first,
// and the checker beside the block predicts and compares each sum
// ----------------------------------------------------------------------------
module tb_circle_outline_intensity_sum;
  timeunit 1ns;
  timeprecision 1ps;
  import cois_pkg::*;

  localparam int ITEM_TARGET    = 1590;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int TAIL_CYCLES    = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int failures;
  int outstanding;
  int idle_cycles = 0;
  int sent_items  = 0;
  int send_calm   = 0;
  bit filled [IMG_DEPTH];

  circle_outline_intensity_sum DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  circle_sum_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int gap_len(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(input int pcol, input int prow,
                                                     input int pval, input int ccol,
                                                     input int crow, input int rad,
                                                     input int part);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[PCOL_LSB +: COL_W] = COL_W'(pcol);
    d[PROW_LSB +: ROW_W] = ROW_W'(prow);
    d[PVAL_LSB +: PIX_W] = PIX_W'(pval);
    d[CCOL_LSB +: COL_W] = COL_W'(ccol);
    d[CROW_LSB +: ROW_W] = ROW_W'(crow);
    d[RAD_LSB +: RAD_W]  = RAD_W'(rad);
    d[PART_LSB]          = 1'(part);
    return d;
  endfunction

  task automatic push_item(input logic mode, input logic [IN_DATA_W-1:0] data);
    int g;
    g = gap_len(send_calm);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  // query fields of a write transfer carry random noise
  task automatic put_pixel(input int col, input int row, input int val);
    filled[row * IMAGE_WIDTH + col] = 1'b1;
    push_item(MODE_WRITE, pack_item(col, row, val, $urandom_range(0, 127),
                                    $urandom_range(0, 127), $urandom_range(0, 63),
                                    $urandom_range(0, 1)));
  endtask

  // writes every pixel of the outline that has not been written yet
  task automatic cover_outline(input int ccol, input int crow, input int rad,
                               input bit part);
    int prow [8];
    int pcol [8];
    int x;
    int y;
    int p;
    x = 0;
    y = rad;
    p = 1 - rad;
    forever begin
      prow = '{crow + x, crow - x, crow - x, crow + x, crow + y, crow + y, crow - y, crow - y};
      pcol = '{ccol + y, ccol + y, ccol - y, ccol - y, ccol + x, ccol - x, ccol - x, ccol + x};
      for (int k = 0; k < (part ? 4 : 8); k++) begin
        if (!filled[prow[k] * IMAGE_WIDTH + pcol[k]])
          put_pixel(pcol[k], prow[k], $urandom_range(0, 255));
      end
      if (x >= y) break;
      x++;
      if (p < 0) begin
        p += 2 * x + 1;
      end else begin
        y--;
        p += 2 * (x - y) + 1;
      end
    end
  endtask

  task automatic ask_circle(input int ccol, input int crow, input int rad, input bit part);
    if (ccol - rad >= 0 && ccol + rad <= IMAGE_WIDTH - 1 &&
        crow - rad >= 0 && crow + rad <= IMAGE_HEIGHT - 1)
      cover_outline(ccol, crow, rad, part);
    push_item(MODE_QUERY, pack_item($urandom_range(0, 127), $urandom_range(0, 127),
                                    $urandom_range(0, 255), ccol, crow, rad, part));
  endtask

  initial begin : stimulus
    int roll;
    int rad;
    int lo;
    int hi;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_WRITE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner pixels, three at the value extremes, zero radius at each corner
    put_pixel(0, 0, 255);
    put_pixel(127, 0, 0);
    put_pixel(0, 127, 170);
    put_pixel(127, 127, 255);
    ask_circle(0, 0, 0, 1'b0);
    ask_circle(127, 0, 0, 1'b1);
    ask_circle(0, 127, 0, 1'b0);
    ask_circle(127, 127, 0, 1'b1);
    // small circles; at radius 3 the x = y point appears
    ask_circle(1, 1, 1, 1'b0);
    ask_circle(10, 10, 3, 1'b1);
    ask_circle(10, 10, 3, 1'b0);
    // box just leaving the image on each side
    ask_circle(0, 5, 1, 1'b0);
    ask_circle(127, 5, 1, 1'b1);
    ask_circle(5, 0, 1, 1'b0);
    ask_circle(5, 127, 1, 1'b0);
    ask_circle(62, 64, 63, 1'b1);
    ask_circle(127, 127, 63, 1'b0);
    // largest radius that fits, partial then full
    ask_circle(64, 63, 63, 1'b1);
    ask_circle(64, 63, 63, 1'b0);

    while (sent_items < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        put_pixel($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 255));
      end else if (roll < 35) begin
        // anywhere at any radius, mostly leaving the image
        ask_circle($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 63),
                   1'($urandom_range(0, 1)));
      end else begin
        rad = ($urandom_range(0, 99) < 97) ? $urandom_range(0, 8) : $urandom_range(9, 63);
        // most centres kept in one window so that written pixels get reused
        if (rad <= 8 && $urandom_range(0, 99) < 70) begin
          lo = 20;
          hi = 59;
        end else begin
          lo = rad;
          hi = 127 - rad;
        end
        ask_circle($urandom_range(lo, hi), $urandom_range(lo, hi), rad,
                   1'($urandom_range(0, 1)));
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : sink
    int g;
    int calm;
    int results_seen;
    bit held;
    calm         = 0;
    results_seen = 0;
    held         = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // one long hold-off so the block backs up and stalls its input
      if (!held && results_seen >= 25) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      g = gap_len(calm);
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

/* sim.f */
+incdir+sv
sv/cois_pkg.sv
sv/cois_dp.sv
sv/cois_ctrl.sv
sv/circle_outline_intensity_sum.sv
verif/circle_sum_checker.sv
verif/tb_circle_outline_intensity_sum.sv
